### hw/rtl/qat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qat_pkg;

    // Scan modes of the tokenizer.
    localparam logic [2:0] MODE_BETWEEN  = 3'd0;
    localparam logic [2:0] MODE_UNQUOTED = 3'd1;
    localparam logic [2:0] MODE_QUOTED   = 3'd2;
    localparam logic [2:0] MODE_ESCAPE   = 3'd3;
    localparam logic [2:0] MODE_QSPLIT   = 3'd4;
    localparam logic [2:0] MODE_DROP     = 3'd5;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_V      = 8'h76;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       token_end;
        logic [4:0] token_index;
        logic       line_done;
        logic [5:0] token_count;
        logic       last;
    } qat_res_t;

    // Everything one input byte produces: up to three results.
    typedef struct packed {
        logic [1:0]         n;
        qat_res_t [2:0]     res;
    } qat_scan_out_t;

    function automatic logic [7:0] escape_map(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            CH_N:    r = 8'd10;
            CH_R:    r = 8'd13;
            CH_T:    r = 8'd9;
            CH_A:    r = 8'd7;
            CH_V:    r = 8'd11;
            default: r = b;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/qat_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Byte request channel.
interface qat_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// Token result channel.
interface qat_tok_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       char_valid;
    logic       token_end;
    logic [4:0] token_index;
    logic       line_done;
    logic [5:0] token_count;
    logic       last;

    modport source (output valid, output out_char, output char_valid, output token_end,
                    output token_index, output line_done, output token_count,
                    output last, input ready);
    modport sink   (input valid, input out_char, input char_valid, input token_end,
                    input token_index, input line_done, input token_count,
                    input last, output ready);
endinterface

`default_nettype wire

### hw/rtl/quoted_argument_tokenizer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Modport | Payload                                         | Direction
// ---------+---------+-------------------------------------------------+----------
// char_ch  | sink    | in_byte                                         | in
// token_ch | source  | out_char, char_valid, token_end, token_index,   | out
//          |         | line_done, token_count, last                    |
//
// Each accepted byte is held in an input register, decoded by short logic in
// the scanner and its zero to three results are loaded into a three-entry
// result queue in the same cycle.
// When each byte gives one result or none and token_ch does not stall, a
// request can be accepted on every clock; a byte giving two or three results
// occupies the queue until its results have drained through token_ch.
// Reset (rst_n, asynchronous, active low) empties both registers and puts the
// scanner between tokens with zero counts.
// A stall on token_ch holds the queue head; the input register still takes one
// request, after which char_ch.ready falls until the queue can be reloaded.
module quoted_argument_tokenizer #(
    parameter int MAX_TOKENS  = 32,
    parameter int TOKEN_BYTES = 64
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    qat_byte_if.sink   char_ch,
    qat_tok_if.source  token_ch
);

    logic                       in_valid_reg;
    logic [7:0]                 in_byte_reg;
    qat_pkg::qat_res_t [2:0]    res_q_reg;
    logic [1:0]                 cnt_reg, cnt_next;
    qat_pkg::qat_scan_out_t     scan_out;
    qat_pkg::qat_res_t          head;
    logic                       pop;
    logic                       step;
    logic                       take;

    // The scanner holds the tokenizer state and advances on every step.
    qat_scan #(
        .MAX_TOKENS  (MAX_TOKENS),
        .TOKEN_BYTES (TOKEN_BYTES)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .in_byte  (in_byte_reg),
        .scan_out (scan_out)
    );

    // The queue head is the visible result; it drains one entry per handshake.
    assign head = res_q_reg[0];
    assign pop  = token_ch.valid && token_ch.ready;

    // A held byte is decoded once the queue is empty or loses its last entry now.
    assign step = in_valid_reg && ((cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop));
    assign take = char_ch.valid && char_ch.ready;

    assign char_ch.ready = !in_valid_reg || step;

    always_comb
    begin
        if (step)
        begin
            cnt_next = scan_out.n;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            cnt_reg      <= 2'd0;
        end
        else
        begin
            if (take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                in_valid_reg <= 1'b0;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_byte_reg <= char_ch.in_byte;
        end
        if (step)
        begin
            res_q_reg <= scan_out.res;
        end
        else if (pop)
        begin
            res_q_reg[0] <= res_q_reg[1];
            res_q_reg[1] <= res_q_reg[2];
        end
    end

    assign token_ch.valid       = (cnt_reg != 2'd0);
    assign token_ch.out_char    = head.out_char;
    assign token_ch.char_valid  = head.char_valid;
    assign token_ch.token_end   = head.token_end;
    assign token_ch.token_index = head.token_index;
    assign token_ch.line_done   = head.line_done;
    assign token_ch.token_count = head.token_count;
    assign token_ch.last        = head.last;

`ifndef ASSERT_OFF
    // The final result of a byte is always the last one left in the queue.
    a_last_is_tail : assert property (@(posedge clk) disable iff (!rst_n)
        (token_ch.valid && head.last) |-> (cnt_reg == 2'd1))
        else $error("last flag seen with further results queued");

    // A line end is always the final result of its byte.
    a_done_is_last : assert property (@(posedge clk) disable iff (!rst_n)
        (token_ch.valid && head.line_done) |-> head.last)
        else $error("line_done result without last");

    // Draining without a reload moves the next entry to the head.
    a_queue_shift : assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !step && cnt_reg > 2'd1) |=> (head == $past(res_q_reg[1])))
        else $error("result queue lost an entry");
`endif

endmodule

`default_nettype wire

### hw/rtl/qat_scan.sv
`timescale 1ns / 1ps
`default_nettype none

// Scanner state and the per-byte decode into up to three results.
module qat_scan #(
    parameter int MAX_TOKENS  = 32,
    parameter int TOKEN_BYTES = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic [7:0]            in_byte,
    output qat_pkg::qat_scan_out_t     scan_out
);

    localparam int BCW = (TOKEN_BYTES > 2) ? $clog2(TOKEN_BYTES) : 1;
    localparam logic [BCW-1:0] BC_LAST = BCW'(TOKEN_BYTES - 2);
    localparam logic [5:0] TOK_MAX = 6'(MAX_TOKENS);

    typedef struct packed {
        logic [2:0]                mode;
        logic [BCW-1:0]            bc;
        logic [5:0]                tf;
        logic [1:0]                n;
        qat_pkg::qat_res_t [2:0]   res;
    } ctx_t;

    logic [2:0]     mode_reg, mode_next;
    logic [BCW-1:0] bc_reg, bc_next;
    logic [5:0]     tf_reg, tf_next;
    ctx_t           c;

    function automatic ctx_t put(input ctx_t x, input logic [7:0] ch, input logic v,
                                 input logic e, input logic d, input logic [5:0] cnt);
        ctx_t y;
        y = x;
        if (y.n != 2'd3)
        begin
            y.res[y.n].out_char    = ch;
            y.res[y.n].char_valid  = v;
            y.res[y.n].token_end   = e;
            y.res[y.n].token_index = d ? 5'd0 : y.tf[4:0];
            y.res[y.n].line_done   = d;
            y.res[y.n].token_count = cnt;
            y.res[y.n].last        = 1'b0;
            y.n = y.n + 2'd1;
        end
        return y;
    endfunction

    function automatic ctx_t end_token(input ctx_t x);
        ctx_t y;
        y = put(x, 8'd0, 1'b0, 1'b1, 1'b0, 6'd0);
        y.tf = y.tf + 6'd1;
        y.bc = '0;
        y.mode = (y.tf >= TOK_MAX) ? qat_pkg::MODE_DROP : qat_pkg::MODE_BETWEEN;
        return y;
    endfunction

    function automatic ctx_t add_char(input ctx_t x, input logic [7:0] ch, input logic quoted);
        ctx_t y;
        y = put(x, ch, 1'b1, 1'b0, 1'b0, 6'd0);
        if (y.bc == BC_LAST)
        begin
            y = end_token(y);
            if (quoted && y.mode == qat_pkg::MODE_BETWEEN)
            begin
                y.mode = qat_pkg::MODE_QSPLIT;
            end
        end
        else
        begin
            y.bc = y.bc + BCW'(1);
        end
        return y;
    endfunction

    function automatic ctx_t start_between(input ctx_t x, input logic [7:0] b);
        ctx_t y;
        y = x;
        y.mode = qat_pkg::MODE_BETWEEN;
        if (b != qat_pkg::CH_SPACE)
        begin
            y.bc = '0;
            if (b == qat_pkg::CH_QUOTE)
            begin
                y.mode = qat_pkg::MODE_QUOTED;
            end
            else
            begin
                y.mode = qat_pkg::MODE_UNQUOTED;
                y = add_char(y, b, 1'b0);
            end
        end
        return y;
    endfunction

    always_comb
    begin
        c      = '0;
        c.mode = mode_reg;
        c.bc   = bc_reg;
        c.tf   = tf_reg;
        if (in_byte == qat_pkg::CH_NUL)
        begin
            if (c.mode == qat_pkg::MODE_ESCAPE)
            begin
                // A trailing backslash is kept as a literal byte.
                c = add_char(c, qat_pkg::CH_BSLASH, 1'b1);
                if (c.mode == qat_pkg::MODE_ESCAPE)
                begin
                    c.mode = qat_pkg::MODE_QUOTED;
                end
            end
            if (c.mode == qat_pkg::MODE_QUOTED || c.mode == qat_pkg::MODE_UNQUOTED)
            begin
                c = end_token(c);
            end
            c = put(c, 8'd0, 1'b0, 1'b0, 1'b1, c.tf);
            c.mode = qat_pkg::MODE_BETWEEN;
            c.bc   = '0;
            c.tf   = 6'd0;
        end
        else
        begin
            case (mode_reg)
                qat_pkg::MODE_UNQUOTED:
                begin
                    if (in_byte == qat_pkg::CH_SPACE)
                    begin
                        c = end_token(c);
                    end
                    else
                    begin
                        c = add_char(c, in_byte, 1'b0);
                    end
                end
                qat_pkg::MODE_QUOTED:
                begin
                    if (in_byte == qat_pkg::CH_QUOTE)
                    begin
                        c = end_token(c);
                    end
                    else if (in_byte == qat_pkg::CH_BSLASH)
                    begin
                        c.mode = qat_pkg::MODE_ESCAPE;
                    end
                    else
                    begin
                        c = add_char(c, in_byte, 1'b1);
                    end
                end
                qat_pkg::MODE_ESCAPE:
                begin
                    c.mode = qat_pkg::MODE_QUOTED;
                    c = add_char(c, qat_pkg::escape_map(in_byte), 1'b1);
                end
                qat_pkg::MODE_QSPLIT:
                begin
                    // A closing quote right after a split quoted token is swallowed.
                    if (in_byte == qat_pkg::CH_QUOTE)
                    begin
                        c.mode = qat_pkg::MODE_BETWEEN;
                    end
                    else
                    begin
                        c = start_between(c, in_byte);
                    end
                end
                qat_pkg::MODE_DROP:
                begin
                    c.mode = qat_pkg::MODE_DROP;
                end
                default:
                begin
                    c = start_between(c, in_byte);
                end
            endcase
        end
        if (c.n != 2'd0)
        begin
            c.res[c.n - 2'd1].last = 1'b1;
        end
    end

    assign mode_next    = c.mode;
    assign bc_next      = c.bc;
    assign tf_next      = c.tf;
    assign scan_out.n   = c.n;
    assign scan_out.res = c.res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= qat_pkg::MODE_BETWEEN;
            bc_reg   <= '0;
            tf_reg   <= 6'd0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            bc_reg   <= bc_next;
            tf_reg   <= tf_next;
        end
    end

endmodule

`default_nettype wire
